/* src/sfd_pkg.sv */
// ============================================================================
// sfd_pkg
// Shared types, constants and the CRC-16/CCITT-FALSE byte update for the
// length-prefixed frame deframer.
// ============================================================================
package sfd_pkg;

    // Framing constants
    localparam logic [7:0]  SYNC_BYTE = 8'hA5;
    localparam logic [2:0]  SYNC_RUN  = 3'd4;
    localparam logic [15:0] CRC_POLY  = 16'h1021;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    // One result beat, before packing onto the output stream
    typedef struct packed {
        logic       body_valid;
        logic [7:0] body_byte;
        logic [7:0] body_index;
        logic       frame_end;
        logic       crc_good;
        logic [7:0] frame_command;
        logic [7:0] frame_length;
    } sfd_result_t;

    // One byte of CRC-16, MSB first, no reflection
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            if (crc[15])
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            else
                crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

/* src/sfd_parser.sv */
// ============================================================================
// sfd_parser
// Frame parser: sync hunt, length capture, body indexing and CRC check.
// Computes one result per byte; the state advances when adv is high.
// ============================================================================
module sfd_parser
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                adv,
    input  logic [7:0]          rx_byte,
    output sfd_pkg::sfd_result_t result
);

    typedef enum logic [1:0]
    {
        MODE_HUNT = 2'd0,
        MODE_LEN  = 2'd1,
        MODE_DATA = 2'd2
    } mode_t;

    mode_t       mode_reg,      mode_next;
    logic [2:0]  sync_cnt_reg,  sync_cnt_next;
    logic [7:0]  exp_cnt_reg,   exp_cnt_next;
    logic [7:0]  rcv_cnt_reg,   rcv_cnt_next;
    logic [15:0] crc_reg,       crc_next;
    logic [7:0]  crc_hi_reg,    crc_hi_next;
    logic [7:0]  cmd_reg,       cmd_next;
    logic [7:0]  len_byte_reg,  len_byte_next;

    // Values seen by the body logic; a length byte restarts the frame
    logic        starting;
    logic        take_body;
    logic [7:0]  idx_eff;
    logic [7:0]  len_eff;
    logic [15:0] crc_eff;
    logic [7:0]  crc_hi_eff;
    logic [7:0]  cmd_eff;
    logic [7:0]  len_byte_eff;
    logic [15:0] crc_upd;
    logic        crc_cover;
    logic        hi_hit;
    logic        last_byte;

    assign starting     = (mode_reg == MODE_LEN);
    assign idx_eff      = starting ? 8'd0 : rcv_cnt_reg;
    assign len_eff      = starting ? rx_byte : exp_cnt_reg;
    assign crc_eff      = starting ? sfd_pkg::CRC_INIT : crc_reg;
    assign crc_hi_eff   = starting ? 8'd0 : crc_hi_reg;
    assign cmd_eff      = starting ? 8'd0 : cmd_reg;
    assign len_byte_eff = starting ? rx_byte : len_byte_reg;

    assign crc_upd   = sfd_pkg::crc16_byte(crc_eff, rx_byte);
    assign crc_cover = ({1'b0, idx_eff} + 9'd2) <= {1'b0, len_eff};
    assign hi_hit    = ({1'b0, idx_eff} + 9'd1) == {1'b0, len_eff};
    assign last_byte = idx_eff >= len_eff;

    // Next state and result
    always_comb
    begin
        mode_next     = mode_reg;
        sync_cnt_next = sync_cnt_reg;
        exp_cnt_next  = exp_cnt_reg;
        rcv_cnt_next  = rcv_cnt_reg;
        crc_next      = crc_reg;
        crc_hi_next   = crc_hi_reg;
        cmd_next      = cmd_reg;
        len_byte_next = len_byte_reg;
        take_body     = 1'b0;
        result        = '0;

        case (mode_reg)
            MODE_HUNT:
            begin
                if (rx_byte == sfd_pkg::SYNC_BYTE)
                begin
                    if (sync_cnt_reg == sfd_pkg::SYNC_RUN - 3'd1)
                    begin
                        sync_cnt_next = 3'd0;
                        mode_next     = MODE_LEN;
                    end
                    else
                    begin
                        sync_cnt_next = sync_cnt_reg + 3'd1;
                    end
                end
                else
                begin
                    sync_cnt_next = 3'd0;
                end
            end
            MODE_LEN:
            begin
                // sync and zero bytes are skipped while waiting for a length
                if (rx_byte != sfd_pkg::SYNC_BYTE && rx_byte != 8'd0)
                    take_body = 1'b1;
            end
            MODE_DATA:
            begin
                take_body = 1'b1;
            end
            default:
            begin
                mode_next     = MODE_HUNT;
                sync_cnt_next = 3'd0;
            end
        endcase

        if (take_body)
        begin
            result.body_valid = 1'b1;
            result.body_byte  = rx_byte;
            result.body_index = idx_eff;
            exp_cnt_next      = len_eff;
            len_byte_next     = len_byte_eff;
            cmd_next          = (idx_eff == 8'd1) ? rx_byte : cmd_eff;
            crc_next          = crc_cover ? crc_upd : crc_eff;
            crc_hi_next       = hi_hit ? rx_byte : crc_hi_eff;

            if (last_byte)
            begin
                // low CRC byte closes the frame
                result.frame_end     = 1'b1;
                result.crc_good      = (crc_hi_eff == crc_eff[15:8]) &&
                                       (rx_byte == crc_eff[7:0]);
                result.frame_command = cmd_next;
                result.frame_length  = len_byte_eff;
                mode_next            = MODE_HUNT;
                sync_cnt_next        = 3'd0;
                rcv_cnt_next         = 8'd0;
                crc_next             = sfd_pkg::CRC_INIT;
            end
            else
            begin
                mode_next    = MODE_DATA;
                rcv_cnt_next = idx_eff + 8'd1;
            end
        end
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_HUNT;
            sync_cnt_reg <= 3'd0;
            exp_cnt_reg  <= 8'd0;
            rcv_cnt_reg  <= 8'd0;
            crc_reg      <= sfd_pkg::CRC_INIT;
            crc_hi_reg   <= 8'd0;
            cmd_reg      <= 8'd0;
            len_byte_reg <= 8'd0;
        end
        else if (adv)
        begin
            mode_reg     <= mode_next;
            sync_cnt_reg <= sync_cnt_next;
            exp_cnt_reg  <= exp_cnt_next;
            rcv_cnt_reg  <= rcv_cnt_next;
            crc_reg      <= crc_next;
            crc_hi_reg   <= crc_hi_next;
            cmd_reg      <= cmd_next;
            len_byte_reg <= len_byte_next;
        end
    end

    // Checks
    a_end_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        adv && result.frame_end |=> mode_reg == MODE_HUNT && rcv_cnt_reg == 8'd0)
        else $error("frame end did not return to sync hunt");

    a_sync_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HUNT |-> sync_cnt_reg < sfd_pkg::SYNC_RUN)
        else $error("sync count ran past the sync run");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_DATA |-> rcv_cnt_reg <= exp_cnt_reg && rcv_cnt_reg != 8'd0)
        else $error("body index outside the frame");

    a_len_start: assert property (@(posedge clk) disable iff (!rst_n)
        adv && mode_reg == MODE_LEN && result.body_valid
        |=> mode_reg == MODE_DATA && rcv_cnt_reg == 8'd1)
        else $error("length byte did not start collection");

endmodule

/* src/serial_frame_deframer_crc16.sv */
// ============================================================================
// serial_frame_deframer_crc16
// Length-prefixed frame deframer with CRC-16/CCITT-FALSE check, one byte in
// and one result beat out per byte.
// ============================================================================
// Path: an input beat passes through the input register and the parser logic
//   into the result register.
// Throughput: one byte per cycle; while a result waits to be taken, the input
//   register holds one more byte and then the input stalls.
// Reset: rst_n clears both pipeline valids and puts the parser in sync hunt
//   with the CRC at 0xFFFF.
module serial_frame_deframer_crc16
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] body_byte, [15:8] body_index,
                                        // [23:16] frame_command, [31:24] frame_length
    output logic        m_axis_tlast,   // frame_end
    output logic [1:0]  m_axis_tuser    // [0] body_valid, [1] crc_good
);

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_byte_reg;
    logic                out_valid_reg, out_valid_next;
    sfd_pkg::sfd_result_t out_res_reg;
    sfd_pkg::sfd_result_t res;
    logic                in_take;
    logic                out_load;

    // Handshake
    assign out_load      = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || out_load;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
            in_valid_next = 1'b1;
        else if (out_load)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
            in_byte_reg <= s_axis_tdata;
        if (out_load)
            out_res_reg <= res;
    end

    // Parser
    sfd_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (out_load),
        .rx_byte (in_byte_reg),
        .result  (res)
    );

    // Output packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_res_reg.frame_length, out_res_reg.frame_command,
                            out_res_reg.body_index, out_res_reg.body_byte};
    assign m_axis_tlast  = out_res_reg.frame_end;
    assign m_axis_tuser  = {out_res_reg.crc_good, out_res_reg.body_valid};

endmodule
